// ===== rtl/assert_macros.svh =====
// Assertion macros used by the cache datapath RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Concurrent assertion, clocked on the rising edge and disabled during reset.
`define LKV_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
// Concurrent assertion that is also checked during reset.
`define LKV_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define LKV_ASSERT(lbl, clk, rstn, prop)
`define LKV_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ===== rtl/lkv_pkg.sv =====
// Shared types and constants of the LRU key-value cache.
package lkv_pkg;

  localparam int unsigned DefaultEntries = 16;
  localparam int unsigned CapW = 5;
  localparam logic [CapW-1:0] CapResetVal = 5'd16;
  localparam logic [31:0] MissValue = 32'hFFFF_FFFF;

  localparam logic KindGet = 1'b0;
  localparam logic KindPut = 1'b1;

  typedef struct packed {
    logic               kind;
    logic signed [31:0] lookup_key;
    logic signed [31:0] store_value;
  } req_t;

  typedef struct packed {
    logic               found;
    logic signed [31:0] read_value;
  } rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_SWEEP
  } state_e;

  // Controller to datapath.
  typedef struct packed {
    logic load;
    logic scan;
    logic decide;
    logic sweep;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic pass_last;
    logic need_sweep;
  } status_t;

endpackage

// ===== rtl/lkv_ctrl.sv =====
// Controller state machine of the LRU key-value cache.
module lkv_ctrl
  import lkv_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start,
  input  status_t status_i,
  output cmd_t    cmd_o,
  output logic    busy
);

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (status_i.pass_last) state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        state_d = status_i.need_sweep ? ST_SWEEP : ST_IDLE;
      end
      ST_SWEEP: begin
        if (status_i.pass_last) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    busy  = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        busy       = 1'b0;
        cmd_o.load = start;
      end
      ST_SCAN:   cmd_o.scan   = 1'b1;
      ST_DECIDE: cmd_o.decide = 1'b1;
      ST_SWEEP:  cmd_o.sweep  = 1'b1;
      default:   busy = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/lkv_datapath.sv =====
// Datapath of the LRU key-value cache: slot memories, scan trackers and rank sweep.
`include "assert_macros.svh"
module lkv_datapath
  import lkv_pkg::*;
#(
  parameter int unsigned ENTRIES = DefaultEntries
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cmd_t            cmd_i,
  output status_t         status_o,
  input  req_t            req_i,
  input  logic            cfg_we_i,
  input  logic [CapW-1:0] cfg_wdata_i,
  output logic            result_valid_o,
  output rsp_t            rsp_o
);

  localparam int unsigned IdxW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned RankW = IdxW;
  localparam int unsigned CntW  = $clog2(ENTRIES + 1);
  localparam int unsigned CmpW  = (CntW > CapW) ? CntW : CapW;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(ENTRIES - 1);

  // Slot storage.
  logic [31:0]      key_mem  [ENTRIES];
  logic [31:0]      val_mem  [ENTRIES];
  logic [RankW-1:0] rank_mem [ENTRIES];
  logic [31:0]      key_rd_q, val_rd_q;
  logic [RankW-1:0] rank_rd_q;

  logic [ENTRIES-1:0] valid_q;
  logic [CntW-1:0]    occ_q;
  logic [CapW-1:0]    cap_q;

  // Pass sequencer: one read per cycle, data processed in the cycle after the read.
  logic [IdxW-1:0] step_q, pend_addr_q;
  logic            run_q, pend_q;

  req_t item_q;

  // Scan trackers.
  logic             hit_q, lru_any_q, free_any_q;
  logic [IdxW-1:0]  hit_slot_q, lru_slot_q, free_slot_q;
  logic [RankW-1:0] hit_rank_q, lru_rank_q;
  logic [31:0]      hit_val_q;

  // Sweep plan, settled at the decision step.
  logic [IdxW-1:0]  tgt_q, tgt_d;
  logic [RankW-1:0] thr_q, thr_d;
  logic             inc_all_q, inc_all_d;
  logic             write_kv_q, write_kv_d;
  logic             insert_d, need_sweep;

  logic             result_valid_q;
  rsp_t             rsp_q;

  logic [CmpW-1:0]  cap_ext, eff_cap;
  logic             full;

  logic             key_we, rank_we;
  logic [RankW-1:0] rank_wdata;
  logic             pend_valid;

  assign pend_valid = valid_q[pend_addr_q];

  always_comb begin
    cap_ext = CmpW'(cap_q);
    if (cap_ext == '0) begin
      eff_cap = CmpW'(1);
    end else if (cap_ext > CmpW'(ENTRIES)) begin
      eff_cap = CmpW'(ENTRIES);
    end else begin
      eff_cap = cap_ext;
    end
    full = (CmpW'(occ_q) >= eff_cap) && (occ_q != '0);
  end

  // Decision after the scan.
  always_comb begin
    tgt_d      = hit_slot_q;
    thr_d      = hit_rank_q;
    inc_all_d  = 1'b0;
    write_kv_d = 1'b0;
    insert_d   = 1'b0;
    need_sweep = hit_q;
    if (item_q.kind == KindPut) begin
      need_sweep = 1'b1;
      write_kv_d = 1'b1;
      if (!hit_q) begin
        if (full) begin
          tgt_d = lru_slot_q;
          thr_d = lru_rank_q;
        end else begin
          tgt_d     = free_slot_q;
          inc_all_d = 1'b1;
          insert_d  = 1'b1;
        end
      end
    end
  end

  assign status_o.pass_last  = pend_q && (pend_addr_q == LastIdx);
  assign status_o.need_sweep = need_sweep;

  // Sweep write decisions for the entry whose rank was just read.
  always_comb begin
    key_we     = 1'b0;
    rank_we    = 1'b0;
    rank_wdata = rank_rd_q + RankW'(1);
    if (cmd_i.sweep && pend_q) begin
      if (pend_addr_q == tgt_q) begin
        rank_we    = 1'b1;
        rank_wdata = '0;
        key_we     = write_kv_q;
      end else if (pend_valid && (inc_all_q || (rank_rd_q < thr_q))) begin
        rank_we = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    key_rd_q  <= key_mem[step_q];
    val_rd_q  <= val_mem[step_q];
    rank_rd_q <= rank_mem[step_q];
    if (key_we) begin
      key_mem[pend_addr_q] <= item_q.lookup_key;
      val_mem[pend_addr_q] <= item_q.store_value;
    end
    if (rank_we) begin
      rank_mem[pend_addr_q] <= rank_wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q        <= '0;
      occ_q          <= '0;
      cap_q          <= CapResetVal;
      run_q          <= 1'b0;
      pend_q         <= 1'b0;
      step_q         <= '0;
      pend_addr_q    <= '0;
      result_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) cap_q <= cfg_wdata_i;
      pend_q      <= run_q;
      pend_addr_q <= step_q;
      if (cmd_i.load || (cmd_i.decide && need_sweep)) begin
        run_q  <= 1'b1;
        step_q <= '0;
      end else if (run_q) begin
        step_q <= step_q + IdxW'(1);
        if (step_q == LastIdx) run_q <= 1'b0;
      end
      result_valid_q <= cmd_i.decide && (item_q.kind == KindGet);
      if (cmd_i.decide && insert_d) begin
        valid_q[free_slot_q] <= 1'b1;
        occ_q                <= occ_q + CntW'(1);
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q     <= req_i;
      hit_q      <= 1'b0;
      lru_any_q  <= 1'b0;
      free_any_q <= 1'b0;
    end else if (cmd_i.scan && pend_q) begin
      if (pend_valid && (key_rd_q == item_q.lookup_key)) begin
        hit_q      <= 1'b1;
        hit_slot_q <= pend_addr_q;
        hit_rank_q <= rank_rd_q;
        hit_val_q  <= val_rd_q;
      end
      if (pend_valid && (!lru_any_q || (rank_rd_q > lru_rank_q))) begin
        lru_any_q  <= 1'b1;
        lru_slot_q <= pend_addr_q;
        lru_rank_q <= rank_rd_q;
      end
      if (!pend_valid && !free_any_q) begin
        free_any_q  <= 1'b1;
        free_slot_q <= pend_addr_q;
      end
    end
    if (cmd_i.decide) begin
      tgt_q            <= tgt_d;
      thr_q            <= thr_d;
      inc_all_q        <= inc_all_d;
      write_kv_q       <= write_kv_d;
      rsp_q.found      <= hit_q;
      rsp_q.read_value <= hit_q ? hit_val_q : MissValue;
    end
  end

  assign result_valid_o = result_valid_q;
  assign rsp_o          = rsp_q;

  `LKV_ASSERT(a_occ_matches_valid, clk_i, rst_ni, $countones(valid_q) == occ_q)
  `LKV_ASSERT(a_result_after_decide, clk_i, rst_ni, result_valid_q |-> $past(cmd_i.decide))
  `LKV_ASSERT(a_pend_follows_read, clk_i, rst_ni, pend_q |-> $past(run_q))
  `LKV_ASSERT(a_insert_has_room, clk_i, rst_ni,
              (cmd_i.decide && insert_d) |-> (free_any_q && !valid_q[free_slot_q]))

endmodule

// ===== rtl/lru_key_value_cache_core.sv =====
// Top level of the fully associative LRU key-value cache.
//
// Usage: present a request word on req_i and raise start; it is taken at a
// rising edge where start is high and busy is low. A get (kind 0) looks up
// lookup_key and returns one response word on rsp_o, marked by result_valid_o
// for exactly one cycle: found is 1 with the stored value on a hit, or 0 with
// all ones on a miss. A put (kind 1) updates or inserts the key and returns
// no word; a new key takes the lowest free slot or replaces the least recent
// entry once the occupancy reaches the configured capacity.
// Sequence: each request first scans all ENTRIES slots, one memory read per
// cycle, then takes a decision step; the get response appears in the cycle
// after that. Hits and puts then run a second pass over the rank memory to
// age entries, with a read-modify-write of each rank. Reset clears all valid
// bits and the occupancy at once, and sets the capacity register to 16; no
// clearing pass is needed. The capacity register is written through
// cfg_we_i/cfg_wdata_i; the user must write it only while the block is
// idle, which the block itself does not enforce.
// The receiver cannot stall: each response word must be taken as it appears.
module lru_key_value_cache_core
  import lkv_pkg::*;
#(
  parameter int unsigned ENTRIES = DefaultEntries
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  req_t            req_i,
  input  logic            cfg_we_i,
  input  logic [CapW-1:0] cfg_wdata_i,
  output logic            result_valid_o,
  output rsp_t            rsp_o
);

  // The controller sequences scan, decision and sweep; the datapath holds
  // the slot memories and the valid bits and does the comparisons.
  cmd_t    cmd;
  status_t status;

  lkv_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .status_i (status),
    .cmd_o    (cmd),
    .busy     (busy)
  );

  lkv_datapath #(
    .ENTRIES (ENTRIES)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .req_i          (req_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .result_valid_o (result_valid_o),
    .rsp_o          (rsp_o)
  );

endmodule
